// ===== src/hbp_pkg.sv =====
// ----------------------------------------------------------------------------
// hbp_pkg: shared types and constants for the hash block permute unit
// Widths, register codes, reset values and the reciprocal table that turns
// the block count into block boundaries without a divider.
// ----------------------------------------------------------------------------
package hbp_pkg;

    // Word and block geometry
    localparam int HASH_BITS     = 64;
    localparam int MAX_BLOCKS    = 16;
    localparam int ENTRY_BITS    = 4;
    localparam int ORDER_ENTRIES = 16;
    localparam int LANES         = (MAX_BLOCKS < ORDER_ENTRIES) ? MAX_BLOCKS : ORDER_ENTRIES;
    localparam int LANE_IDX_W    = $clog2(LANES);

    // Field widths
    localparam int COUNT_W   = 5;                        // block count register
    localparam int DIFF_W    = 4;                        // differing blocks register
    localparam int POS_W     = $clog2(HASH_BITS) + 1;    // bit position 0..64, sums up to 75
    localparam int SHIFT_W   = POS_W + 1;                // signed slot offset
    localparam int RECIP_FRAC = 16;
    localparam int RECIP_W   = RECIP_FRAC + 1;
    localparam int RECIP_SHIFT = RECIP_FRAC - $clog2(HASH_BITS);
    localparam int PROD_W    = RECIP_W + ENTRY_BITS;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = HASH_BITS;

    localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_COUNT      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DIFFERING_BLOCKS = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_ORDER      = 2'd2;

    // Register reset values (identity order)
    localparam logic [COUNT_W-1:0]   BLOCK_COUNT_RST      = 5'd16;
    localparam logic [DIFF_W-1:0]    DIFFERING_BLOCKS_RST = 4'd3;
    localparam logic [HASH_BITS-1:0] BLOCK_ORDER_RST      = 64'hFEDC_BA98_7654_3210;

    // ceil(2^16 / n): floor(b*64/n) == (b * RECIP[n]) >> 10 for all b <= n <= 16
    localparam logic [RECIP_W-1:0] RECIP [0:ORDER_ENTRIES] = '{
        17'd0,     17'd65536, 17'd32768, 17'd21846, 17'd16384, 17'd13108,
        17'd10923, 17'd9363,  17'd8192,  17'd7282,  17'd6554,  17'd5958,
        17'd5462,  17'd5042,  17'd4682,  17'd4370,  17'd4096
    };

    // Span stage to slot stage: block start and width per order entry
    typedef struct packed {
        logic                              req_type;
        logic [HASH_BITS-1:0]              hash_value;
        logic                              err;
        logic [COUNT_W-1:0]                lead;
        logic [LANES-1:0][POS_W-1:0]       start;
        logic [LANES-1:0][POS_W-1:0]       width;
    } hbp_span_t;

    // Slot stage to move stage: source and destination offsets per lane
    typedef struct packed {
        logic [HASH_BITS-1:0]              hash_value;
        logic                              err;
        logic [HASH_BITS-1:0]              mask;
        logic [LANES-1:0][SHIFT_W-1:0]     src;
        logic [LANES-1:0][SHIFT_W-1:0]     dst;
        logic [LANES-1:0][POS_W-1:0]       width;
    } hbp_move_t;

endpackage

// ===== src/hbp_if.sv =====
// ----------------------------------------------------------------------------
// hbp_req_if / hbp_rsp_if: valid/ready channels of the hash block permute unit
// The request channel carries a hash and its direction, the response channel
// the rearranged hash, the search mask and the error flag.
// ----------------------------------------------------------------------------
interface hbp_req_if import hbp_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 req_type;
    logic [HASH_BITS-1:0] hash_value;

    modport source (output valid, output req_type, output hash_value, input ready);
    modport sink   (input valid, input req_type, input hash_value, output ready);
endinterface

interface hbp_rsp_if import hbp_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [HASH_BITS-1:0] result_hash;
    logic [HASH_BITS-1:0] prefix_mask;
    logic                 config_error;

    modport source (output valid, output result_hash, output prefix_mask,
                    output config_error, input ready);
    modport sink   (input valid, input result_hash, input prefix_mask,
                    input config_error, output ready);
endinterface

// ===== src/hbp_span.sv =====
// ----------------------------------------------------------------------------
// hbp_span: configuration decode and block span lanes
// Stage A snapshots the request with the effective block count, the error
// flag and the reciprocal. Stage B gives every order entry its block start
// and width, one small multiplier per lane.
// ----------------------------------------------------------------------------
module hbp_span import hbp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_ready,
    input  logic                   req_type,
    input  logic [HASH_BITS-1:0]   hash_value,
    input  logic [COUNT_W-1:0]     block_count,
    input  logic [DIFF_W-1:0]      differing_blocks,
    input  logic [HASH_BITS-1:0]   block_order,
    output logic                   span_valid,
    input  logic                   span_ready,
    output hbp_span_t              span_data
);

    typedef struct packed {
        logic                 req_type;
        logic [HASH_BITS-1:0] hash_value;
        logic                 err;
        logic [COUNT_W-1:0]   lead;
        logic [COUNT_W-1:0]   nb;
        logic [RECIP_W-1:0]   recip;
        logic [HASH_BITS-1:0] order;
    } span_cfg_t;

    span_cfg_t          a_reg;
    span_cfg_t          a_next;
    logic               a_valid_reg;
    logic               a_ready;
    hbp_span_t          b_reg;
    hbp_span_t          b_next;
    logic               b_valid_reg;
    logic               b_ready;
    logic [COUNT_W-1:0] nb;

    // Stall chain: a stage loads when empty or when its successor loads
    assign b_ready   = !b_valid_reg || span_ready;
    assign a_ready   = !a_valid_reg || b_ready;
    assign req_ready = a_ready;

    // Decode the block count and the error condition
    always_comb
    begin
        nb = (block_count > COUNT_W'(LANES)) ? COUNT_W'(LANES) : block_count;
        a_next.req_type   = req_type;
        a_next.hash_value = hash_value;
        a_next.nb         = nb;
        a_next.err        = (nb <= {1'b0, differing_blocks});
        a_next.lead       = nb - {1'b0, differing_blocks};
        a_next.recip      = RECIP[nb];
        a_next.order      = block_order;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_ready)
        begin
            a_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && req_valid)
        begin
            a_reg <= a_next;
        end
    end

    // Compute start and width of the block named by each order entry
    always_comb
    begin
        logic [ENTRY_BITS-1:0] blk;
        logic [PROD_W-1:0]     prod_lo;
        logic [PROD_W-1:0]     prod_hi;
        logic                  active;
        logic [POS_W-1:0]      lo;
        logic [POS_W-1:0]      hi;
        b_next.req_type   = a_reg.req_type;
        b_next.hash_value = a_reg.hash_value;
        b_next.err        = a_reg.err;
        b_next.lead       = a_reg.lead;
        for (int k = 0; k < LANES; k++)
        begin
            blk     = a_reg.order[k*ENTRY_BITS +: ENTRY_BITS];
            active  = (COUNT_W'(k) < a_reg.nb) && ({1'b0, blk} < a_reg.nb);
            prod_lo = PROD_W'(blk) * PROD_W'(a_reg.recip);
            prod_hi = prod_lo + PROD_W'(a_reg.recip);
            lo      = prod_lo[RECIP_SHIFT +: POS_W];
            hi      = prod_hi[RECIP_SHIFT +: POS_W];
            b_next.start[k] = active ? lo : '0;
            b_next.width[k] = active ? (hi - lo) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (b_ready)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_ready && a_valid_reg)
        begin
            b_reg <= b_next;
        end
    end

    assign span_valid = b_valid_reg;
    assign span_data  = b_reg;

    // Every lane span stays inside the hash word
    for (genvar g = 0; g < LANES; g++)
    begin : g_span_chk
        a_span_inside: assert property (@(posedge clk) disable iff (!rst_n)
            b_valid_reg && (b_reg.width[g] != '0)
            |-> ({1'b0, b_reg.start[g]} + {1'b0, b_reg.width[g]}) <= SHIFT_W'(HASH_BITS))
            else $error("block span runs past the top of the hash");
    end

endmodule

// ===== src/hbp_slot.sv =====
// ----------------------------------------------------------------------------
// hbp_slot: slot stacking and search mask
// A parallel prefix sum over the lane widths places each block below the
// ones before it; the direction then picks source and destination offsets.
// The mask covers the widths of the leading entries.
// ----------------------------------------------------------------------------
module hbp_slot import hbp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        span_valid,
    output logic        span_ready,
    input  hbp_span_t   span_data,
    output logic        slot_valid,
    input  logic        slot_ready,
    output hbp_move_t   slot_data
);

    hbp_move_t          c_reg;
    hbp_move_t          c_next;
    logic               c_valid_reg;
    logic               c_ready;
    logic [POS_W-1:0]   scan [0:LANES-1];
    logic [POS_W-1:0]   used [0:LANES-1];

    assign c_ready    = !c_valid_reg || slot_ready;
    assign span_ready = c_ready;

    // Inclusive prefix sum of widths, log2(LANES) levels
    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            scan[k] = span_data.width[k];
        end
        for (int d = 1; d < LANES; d = d * 2)
        begin
            for (int k = LANES - 1; k >= d; k--)
            begin
                scan[k] = scan[k] + scan[k-d];
            end
        end
        used[0] = '0;
        for (int k = 1; k < LANES; k++)
        begin
            used[k] = scan[k-1];
        end
    end

    // Pick offsets per direction and build the search mask
    always_comb
    begin
        logic [SHIFT_W-1:0] slot_pos;
        logic [SHIFT_W-1:0] home_pos;
        logic [COUNT_W-1:0] lead_m1;
        logic [POS_W-1:0]   prefix;
        c_next.hash_value = span_data.hash_value;
        c_next.err        = span_data.err;
        for (int k = 0; k < LANES; k++)
        begin
            slot_pos = SHIFT_W'(HASH_BITS) - {1'b0, used[k]} - {1'b0, span_data.width[k]};
            home_pos = {1'b0, span_data.start[k]};
            c_next.src[k]   = span_data.req_type ? slot_pos : home_pos;
            c_next.dst[k]   = span_data.req_type ? home_pos : slot_pos;
            c_next.width[k] = span_data.width[k];
        end
        lead_m1 = span_data.lead - COUNT_W'(1);
        prefix  = scan[lead_m1[LANE_IDX_W-1:0]];
        c_next.mask = span_data.err ? '0 : ~({HASH_BITS{1'b1}} >> prefix);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (c_ready)
        begin
            c_valid_reg <= span_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_ready && span_valid)
        begin
            c_reg <= c_next;
        end
    end

    assign slot_valid = c_valid_reg;
    assign slot_data  = c_reg;

    // Mask is a run of ones from the top bit down
    a_mask_top_run: assert property (@(posedge clk) disable iff (!rst_n)
        c_valid_reg |-> (((~c_reg.mask) & ((~c_reg.mask) + 64'd1)) == '0))
        else $error("search mask is not a contiguous top run");

endmodule

// ===== src/hbp_move.sv =====
// ----------------------------------------------------------------------------
// hbp_move: block move lanes and output register
// Stage D cuts each block out of the hash, stage E shifts it into place,
// merges the lanes and holds the response for the receiver.
// ----------------------------------------------------------------------------
module hbp_move import hbp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   slot_valid,
    output logic                   slot_ready,
    input  hbp_move_t              slot_data,
    output logic                   rsp_valid,
    input  logic                   rsp_ready,
    output logic [HASH_BITS-1:0]   result_hash,
    output logic [HASH_BITS-1:0]   prefix_mask,
    output logic                   config_error
);

    typedef struct packed {
        logic                              err;
        logic [HASH_BITS-1:0]              mask;
        logic [LANES-1:0][SHIFT_W-1:0]     dst;
        logic [LANES-1:0][HASH_BITS-1:0]   field;
    } move_cut_t;

    typedef struct packed {
        logic [HASH_BITS-1:0] result_hash;
        logic [HASH_BITS-1:0] prefix_mask;
        logic                 config_error;
    } move_out_t;

    move_cut_t  d_reg;
    move_cut_t  d_next;
    logic       d_valid_reg;
    logic       d_ready;
    move_out_t  e_reg;
    move_out_t  e_next;
    logic       e_valid_reg;
    logic       e_ready;

    // Shift right by a signed amount (left when negative)
    function automatic logic [HASH_BITS-1:0] take_bits(input logic [HASH_BITS-1:0] h,
                                                      input logic [SHIFT_W-1:0] amt);
        logic [SHIFT_W-1:0] neg;
        neg = -amt;
        return amt[SHIFT_W-1] ? (h << neg) : (h >> amt);
    endfunction

    // Shift left by a signed amount (right when negative)
    function automatic logic [HASH_BITS-1:0] put_bits(input logic [HASH_BITS-1:0] f,
                                                     input logic [SHIFT_W-1:0] amt);
        logic [SHIFT_W-1:0] neg;
        neg = -amt;
        return amt[SHIFT_W-1] ? (f >> neg) : (f << amt);
    endfunction

    assign e_ready    = !e_valid_reg || rsp_ready;
    assign d_ready    = !d_valid_reg || e_ready;
    assign slot_ready = d_ready;

    // Cut each block down to its width
    always_comb
    begin
        d_next.err  = slot_data.err;
        d_next.mask = slot_data.mask;
        for (int k = 0; k < LANES; k++)
        begin
            d_next.dst[k]   = slot_data.dst[k];
            d_next.field[k] = take_bits(slot_data.hash_value, slot_data.src[k])
                              & ~({HASH_BITS{1'b1}} << slot_data.width[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
        end
        else if (d_ready)
        begin
            d_valid_reg <= slot_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (d_ready && slot_valid)
        begin
            d_reg <= d_next;
        end
    end

    // Place and merge the lanes; clear the hash on error
    always_comb
    begin
        logic [HASH_BITS-1:0] acc;
        acc = '0;
        for (int k = 0; k < LANES; k++)
        begin
            acc = acc | put_bits(d_reg.field[k], d_reg.dst[k]);
        end
        e_next.result_hash  = d_reg.err ? '0 : acc;
        e_next.prefix_mask  = d_reg.mask;
        e_next.config_error = d_reg.err;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
        end
        else if (e_ready)
        begin
            e_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (e_ready && d_valid_reg)
        begin
            e_reg <= e_next;
        end
    end

    assign rsp_valid    = e_valid_reg;
    assign result_hash  = e_reg.result_hash;
    assign prefix_mask  = e_reg.prefix_mask;
    assign config_error = e_reg.config_error;

    // An error response carries no hash and no mask
    a_error_clears: assert property (@(posedge clk) disable iff (!rst_n)
        e_valid_reg && e_reg.config_error |-> (e_reg.result_hash == '0)
                                              && (e_reg.prefix_mask == '0))
        else $error("error response with nonzero hash or mask");

endmodule

// ===== src/hash_block_permute_unit.sv =====
// ----------------------------------------------------------------------------
// hash_block_permute_unit: block permutation of a 64-bit hash
// Rearranges (apply) or restores (reverse) the contiguous bit blocks of a
// hash under a programmed block order and returns the search mask.
// ----------------------------------------------------------------------------
// Usage:
//   request  : valid/ready channel with req_type (0 apply, 1 reverse) and
//              hash_value. A request is taken on a clock edge with valid
//              and ready high.
//   result   : valid/ready channel with result_hash, prefix_mask and
//              config_error, one response per request, in request order.
//   cfg_*    : write port for block_count (0), differing_blocks (1) and
//              block_order (2); write only while no request is in flight.
//   Five register stages lie between request and response: config decode,
//   block spans, slot prefix sum, block cut, merge.
//   Throughput is one request per cycle with the receiver ready.
//   A stalled receiver holds the response; bubbles inside the pipe are
//   filled first, then request.ready drops. Nothing is lost or repeated.
//   Reset empties the pipe and loads 16 blocks, 3 differing blocks and the
//   identity order.
// ----------------------------------------------------------------------------
module hash_block_permute_unit import hbp_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_INDEX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    hbp_req_if.sink                  request,
    hbp_rsp_if.source                result
);

    logic [COUNT_W-1:0]    block_count_reg;
    logic [DIFF_W-1:0]     differing_blocks_reg;
    logic [HASH_BITS-1:0]  block_order_reg;

    logic                  span_valid;
    logic                  span_ready;
    hbp_span_t             span_data;
    logic                  slot_valid;
    logic                  slot_ready;
    hbp_move_t             slot_data;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_count_reg      <= BLOCK_COUNT_RST;
            differing_blocks_reg <= DIFFERING_BLOCKS_RST;
            block_order_reg      <= BLOCK_ORDER_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BLOCK_COUNT:      block_count_reg      <= cfg_data[COUNT_W-1:0];
                CFG_DIFFERING_BLOCKS: differing_blocks_reg <= cfg_data[DIFF_W-1:0];
                CFG_BLOCK_ORDER:      block_order_reg      <= cfg_data;
                default:              ;
            endcase
        end
    end

    hbp_span u_span
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .req_valid        (request.valid),
        .req_ready        (request.ready),
        .req_type         (request.req_type),
        .hash_value       (request.hash_value),
        .block_count      (block_count_reg),
        .differing_blocks (differing_blocks_reg),
        .block_order      (block_order_reg),
        .span_valid       (span_valid),
        .span_ready       (span_ready),
        .span_data        (span_data)
    );

    hbp_slot u_slot
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .span_valid (span_valid),
        .span_ready (span_ready),
        .span_data  (span_data),
        .slot_valid (slot_valid),
        .slot_ready (slot_ready),
        .slot_data  (slot_data)
    );

    hbp_move u_move
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .slot_valid   (slot_valid),
        .slot_ready   (slot_ready),
        .slot_data    (slot_data),
        .rsp_valid    (result.valid),
        .rsp_ready    (result.ready),
        .result_hash  (result.result_hash),
        .prefix_mask  (result.prefix_mask),
        .config_error (result.config_error)
    );

    // Requests are refused only when every stage is full behind a stall
    a_full_on_refuse: assert property (@(posedge clk) disable iff (!rst_n)
        !request.ready |-> result.valid && !result.ready && span_valid && slot_valid)
        else $error("request refused while the pipe has room");

endmodule
